// ===== design/nll_pkg.sv =====
// ----------------------------------------------------------------------------
// Number literal lexer package
// Shared constants, parse phase encoding and state/result structures.
// ----------------------------------------------------------------------------
`default_nettype none

package nll_pkg;

    localparam int MAX_LEN = 255;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int OUT_W   = 8;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

    localparam logic [1:0] ST_CONSUMED    = 2'd0;
    localparam logic [1:0] ST_COMPLETE    = 2'd1;
    localparam logic [1:0] ST_NOT_LITERAL = 2'd2;
    localparam logic [1:0] ST_MALFORMED   = 2'd3;

    typedef enum logic [3:0] {
        PH_START    = 4'd0,
        PH_SIGN     = 4'd1,
        PH_NAN_A    = 4'd2,
        PH_NAN_N    = 4'd3,
        PH_CNAN_A   = 4'd4,
        PH_CNAN_N   = 4'd5,
        PH_INF_N    = 4'd6,
        PH_INF_F    = 4'd7,
        PH_WORD_END = 4'd8,
        PH_SPACE_I  = 4'd9,
        PH_ZERO     = 4'd10,
        PH_MANT     = 4'd11,
        PH_EXP_SIGN = 4'd12,
        PH_EXP_DIG  = 4'd13,
        PH_DONE     = 4'd14
    } t_phase;

    typedef struct packed {
        t_phase           phase;
        logic [LEN_W-1:0] len;
        logic             hex;
        logic             pt;
        logic             expo;
        logic             imag;
        logic             mant;
        logic [LEN_W-1:0] int_end;
        logic [LEN_W-1:0] exp_start;
    } t_lex_state;

    typedef struct packed {
        logic [1:0]       status;
        logic [OUT_W-1:0] literal_length;
        logic             hex_form;
        logic             point_seen;
        logic             exponent_seen;
        logic             imaginary;
        logic [OUT_W-1:0] integral_end;
        logic [OUT_W-1:0] exponent_start;
    } t_result;

    localparam t_lex_state LEX_RESET = '{
        phase: PH_START, len: '0, hex: 1'b0, pt: 1'b0, expo: 1'b0,
        imag: 1'b0, mant: 1'b0, int_end: '0, exp_start: '0
    };

endpackage

`default_nettype wire

// ===== design/number_literal_lexer.sv =====
// ----------------------------------------------------------------------------
// Number literal lexer
// Streaming recognizer that classifies one character request per cycle while not stalled.
// ----------------------------------------------------------------------------
// Each request carries one character or an end-of-text mark and yields exactly
// one result request with a status and the literal's running properties. The
// block takes a new request every cycle unless o_stall is high. A request is
// held in the input register, the combinational lexer state transition loads
// its result into the result register, and the receiver takes it from there.
// A result waiting under stall still lets one further request enter the input
// register; the input then stalls until the waiting result is taken.
`default_nettype none

module number_literal_lexer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_literal_length,
    output logic       o_hex_form,
    output logic       o_point_seen,
    output logic       o_exponent_seen,
    output logic       o_imaginary,
    output logic [7:0] o_integral_end,
    output logic [7:0] o_exponent_start
);
    import nll_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_eot;
    t_lex_state r_state;
    t_lex_state n_state;
    t_result    n_res;
    t_result    r_res;
    logic       r_out_valid;
    logic       adv;
    logic       in_acc;

    nll_step u_step (
        .i_cur (r_state),
        .i_ch  (r_ch),
        .i_eot (r_eot),
        .o_nxt (n_state),
        .o_res (n_res)
    );

    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= LEX_RESET;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch  <= i_ch;
            r_eot <= i_end_of_text;
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_res.status;
    assign o_literal_length = r_res.literal_length;
    assign o_hex_form       = r_res.hex_form;
    assign o_point_seen     = r_res.point_seen;
    assign o_exponent_seen  = r_res.exponent_seen;
    assign o_imaginary      = r_res.imaginary;
    assign o_integral_end   = r_res.integral_end;
    assign o_exponent_start = r_res.exponent_start;

endmodule

`default_nettype wire

// ===== design/nll_step.sv =====
// ----------------------------------------------------------------------------
// Number literal lexer step
// Combinational transition for one character: next lexer state and result.
// ----------------------------------------------------------------------------
`default_nettype none

module nll_step (
    input  nll_pkg::t_lex_state i_cur,
    input  logic [7:0]          i_ch,
    input  logic                i_eot,
    output nll_pkg::t_lex_state o_nxt,
    output nll_pkg::t_result    o_res
);
    import nll_pkg::*;

    logic [LEN_W-1:0] len_t;
    logic             is_dec;
    logic             is_hexl;
    logic [7:0]       ch_low;
    logic [7:0]       marker;
    logic [1:0]       st;
    t_lex_state       n;

    assign len_t   = (i_cur.len < LEN_MAX) ? i_cur.len + 1'b1 : i_cur.len;
    assign is_dec  = (i_ch >= "0") && (i_ch <= "9");
    assign is_hexl = ((i_ch >= "a") && (i_ch <= "f")) || ((i_ch >= "A") && (i_ch <= "F"));
    assign ch_low  = i_ch | 8'h20;
    assign marker  = i_cur.hex ? "p" : "e";

    always_comb begin
        n  = i_cur;
        st = ST_CONSUMED;
        unique case (i_cur.phase)
            PH_START, PH_SIGN: begin
                if (i_eot) begin
                    st = (i_cur.phase == PH_START) ? ST_NOT_LITERAL : ST_MALFORMED;
                end else if (i_cur.phase == PH_START && i_ch == "-") begin
                    n.len = len_t;
                    n.phase = PH_SIGN;
                end else if (i_ch == "n") begin
                    n.len = len_t;
                    n.phase = PH_NAN_A;
                end else if (i_ch == "N") begin
                    n.len = len_t;
                    n.phase = PH_CNAN_A;
                end else if (i_ch == "i") begin
                    n.len = len_t;
                    n.phase = PH_INF_N;
                end else if (i_ch == "0") begin
                    n.len = len_t;
                    n.int_end = len_t;
                    n.phase = PH_ZERO;
                end else if (is_dec) begin
                    n.len = len_t;
                    n.mant = 1'b1;
                    n.int_end = len_t;
                    n.phase = PH_MANT;
                end else if (i_ch == ".") begin
                    n.int_end = i_cur.len;
                    n.pt = 1'b1;
                    n.len = len_t;
                    n.phase = PH_MANT;
                end else begin
                    st = ST_NOT_LITERAL;
                end
            end
            PH_NAN_A, PH_NAN_N, PH_CNAN_A, PH_CNAN_N, PH_INF_N, PH_INF_F: begin
                if (i_eot) begin
                    st = ST_MALFORMED;
                end else begin
                    st = ST_MALFORMED;
                    case (i_cur.phase)
                        PH_NAN_A: if (i_ch == "a") begin
                            st = ST_CONSUMED;
                            n.phase = PH_NAN_N;
                        end
                        PH_NAN_N: if (i_ch == "n") begin
                            st = ST_CONSUMED;
                            n.phase = PH_WORD_END;
                        end
                        PH_CNAN_A: if (i_ch == "a") begin
                            st = ST_CONSUMED;
                            n.phase = PH_CNAN_N;
                        end
                        PH_CNAN_N: if (i_ch == "N") begin
                            st = ST_CONSUMED;
                            n.phase = PH_WORD_END;
                        end
                        PH_INF_N: if (i_ch == "n") begin
                            st = ST_CONSUMED;
                            n.phase = PH_INF_F;
                        end
                        PH_INF_F: if (i_ch == "f") begin
                            st = ST_CONSUMED;
                            n.phase = PH_WORD_END;
                        end
                        default: st = ST_MALFORMED;
                    endcase
                    if (st == ST_CONSUMED) begin
                        n.len = len_t;
                    end
                end
            end
            PH_WORD_END: begin
                if (!i_eot && i_ch == " ") begin
                    n.len = len_t;
                    n.phase = PH_SPACE_I;
                end else begin
                    st = ST_COMPLETE;
                end
            end
            PH_SPACE_I: begin
                if (!i_eot && i_ch == "i") begin
                    n.imag = 1'b1;
                    n.len = len_t;
                    n.phase = PH_DONE;
                end else begin
                    st = ST_MALFORMED;
                end
            end
            PH_ZERO, PH_MANT: begin
                if (i_cur.phase == PH_ZERO && i_eot) begin
                    st = ST_COMPLETE;
                end else if (i_cur.phase == PH_ZERO && ch_low == "x") begin
                    n.hex = 1'b1;
                    n.int_end = '0;
                    n.len = len_t;
                    n.phase = PH_MANT;
                end else begin
                    n.phase = PH_MANT;
                    if (i_cur.phase == PH_ZERO) begin
                        n.mant = 1'b1;
                    end
                    if (i_eot) begin
                        st = n.mant ? ST_COMPLETE : ST_MALFORMED;
                    end else if (is_dec || (i_cur.hex && is_hexl)
                                 || (!i_cur.pt && i_ch == ".")) begin
                        if (i_ch == ".") begin
                            n.pt = 1'b1;
                        end
                        n.mant = 1'b1;
                        n.len = len_t;
                        if (!n.pt) begin
                            n.int_end = len_t;
                        end
                    end else if (!n.mant) begin
                        st = ST_MALFORMED;
                    end else if (ch_low == marker) begin
                        n.expo = 1'b1;
                        n.len = len_t;
                        n.exp_start = len_t;
                        n.phase = PH_EXP_SIGN;
                    end else if (i_ch == "i") begin
                        n.imag = 1'b1;
                        n.len = len_t;
                        n.phase = PH_DONE;
                    end else begin
                        st = ST_COMPLETE;
                    end
                end
            end
            PH_EXP_SIGN, PH_EXP_DIG: begin
                n.phase = PH_EXP_DIG;
                if (i_eot) begin
                    st = ST_COMPLETE;
                end else if (i_cur.phase == PH_EXP_SIGN && (i_ch == "+" || i_ch == "-")) begin
                    n.len = len_t;
                end else if (is_dec) begin
                    n.len = len_t;
                end else if (i_ch == "i") begin
                    n.imag = 1'b1;
                    n.len = len_t;
                    n.phase = PH_DONE;
                end else begin
                    st = ST_COMPLETE;
                end
            end
            PH_DONE: begin
                st = ST_COMPLETE;
            end
            default: begin
                st = ST_NOT_LITERAL;
            end
        endcase
    end

    always_comb begin
        o_nxt  = (st == ST_CONSUMED) ? n : LEX_RESET;
        o_res  = '0;
        o_res.status = st;
        if (st == ST_CONSUMED || st == ST_COMPLETE) begin
            o_res.literal_length = OUT_W'(n.len);
            o_res.hex_form       = n.hex;
            o_res.point_seen     = n.pt;
            o_res.exponent_seen  = n.expo;
            o_res.imaginary      = n.imag;
            o_res.integral_end   = OUT_W'(n.int_end);
            o_res.exponent_start = OUT_W'(n.exp_start);
        end
    end

endmodule

`default_nettype wire

// ===== sim/number_literal_lexer_tb.sv =====
// ----------------------------------------------------------------------------
// Number literal lexer testbench
// Streams characters into the lexer with random bursts and output stalls, and
// checks every result against a cycle-free grammar model or a hand-written value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module number_literal_lexer_tb;

    import nll_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 200;
    localparam int TABLE_ROWS = 27;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
        logic       hand;
        t_result    want;
    } t_char_req;

    localparam t_result RES_NONE = '0;
    localparam t_result RES_NOT_LIT = '{status: ST_NOT_LITERAL, default: '0};
    localparam t_result RES_MALFORMED = '{status: ST_MALFORMED, default: '0};
    localparam t_result RES_LONE_ZERO = '{status: ST_COMPLETE, literal_length: 8'd1,
                                          integral_end: 8'd1, default: '0};

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_ch;
    logic       i_end_of_text;
    logic       o_valid;
    logic       i_stall;
    logic [1:0] o_status;
    logic [7:0] o_literal_length;
    logic       o_hex_form;
    logic       o_point_seen;
    logic       o_exponent_seen;
    logic       o_imaginary;
    logic [7:0] o_integral_end;
    logic [7:0] o_exponent_start;

    logic    req_hand;
    t_result req_want;

    t_char_req char_stream[$];
    t_char_req directed_table [TABLE_ROWS];
    t_result   pending_results[$];
    int        fail_count = 0;
    int        cycle_count = 0;

    t_phase           lx_phase;
    logic [LEN_W-1:0] lx_len;
    logic [LEN_W-1:0] lx_int_end;
    logic [LEN_W-1:0] lx_exp_start;
    logic             lx_hex;
    logic             lx_pt;
    logic             lx_expo;
    logic             lx_imag;
    logic             lx_mant;

    number_literal_lexer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_ch             (i_ch),
        .i_end_of_text    (i_end_of_text),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_literal_length (o_literal_length),
        .o_hex_form       (o_hex_form),
        .o_point_seen     (o_point_seen),
        .o_exponent_seen  (o_exponent_seen),
        .o_imaginary      (o_imaginary),
        .o_integral_end   (o_integral_end),
        .o_exponent_start (o_exponent_start)
    );

    always #4 i_clk = ~i_clk;

    function automatic void lex_clear();
        lx_phase = PH_START;
        lx_len = '0;
        lx_int_end = '0;
        lx_exp_start = '0;
        lx_hex = 1'b0;
        lx_pt = 1'b0;
        lx_expo = 1'b0;
        lx_imag = 1'b0;
        lx_mant = 1'b0;
    endfunction

    function automatic void lex_take();
        if (lx_len < LEN_MAX) begin
            lx_len = lx_len + 1'b1;
        end
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [1:0] lex_word(input logic [7:0] c, input logic eot,
                                            input logic [7:0] want, input t_phase nxt);
        if (eot || c != want) begin
            return ST_MALFORMED;
        end
        lex_take();
        lx_phase = nxt;
        return ST_CONSUMED;
    endfunction

    function automatic logic [1:0] lex_suffix(input logic [7:0] c);
        if (c == "i") begin
            lx_imag = 1'b1;
            lex_take();
            lx_phase = PH_DONE;
            return ST_CONSUMED;
        end
        return ST_COMPLETE;
    endfunction

    function automatic logic [1:0] lex_exp_digit(input logic [7:0] c, input logic eot);
        if (eot) begin
            return ST_COMPLETE;
        end
        if (is_dec(c)) begin
            lex_take();
            return ST_CONSUMED;
        end
        return lex_suffix(c);
    endfunction

    function automatic logic [1:0] lex_mant(input logic [7:0] c, input logic eot);
        logic [7:0] marker;
        logic       digit;
        marker = lx_hex ? "p" : "e";
        digit = is_dec(c) || (lx_hex && ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")));
        if (eot) begin
            return lx_mant ? ST_COMPLETE : ST_MALFORMED;
        end
        if (digit || (!lx_pt && c == ".")) begin
            if (c == ".") begin
                lx_pt = 1'b1;
            end
            lx_mant = 1'b1;
            lex_take();
            if (!lx_pt) begin
                lx_int_end = lx_len;
            end
            return ST_CONSUMED;
        end
        if (!lx_mant) begin
            return ST_MALFORMED;
        end
        if ((c | 8'h20) == marker) begin
            lx_expo = 1'b1;
            lex_take();
            lx_exp_start = lx_len;
            lx_phase = PH_EXP_SIGN;
            return ST_CONSUMED;
        end
        return lex_suffix(c);
    endfunction

    function automatic logic [1:0] lex_start(input logic [7:0] c, input logic eot);
        logic first;
        first = (lx_phase == PH_START);
        if (eot) begin
            return first ? ST_NOT_LITERAL : ST_MALFORMED;
        end
        if (first && c == "-") begin
            lex_take();
            lx_phase = PH_SIGN;
            return ST_CONSUMED;
        end
        case (c)
            "n": begin
                lex_take();
                lx_phase = PH_NAN_A;
                return ST_CONSUMED;
            end
            "N": begin
                lex_take();
                lx_phase = PH_CNAN_A;
                return ST_CONSUMED;
            end
            "i": begin
                lex_take();
                lx_phase = PH_INF_N;
                return ST_CONSUMED;
            end
            "0": begin
                lex_take();
                lx_int_end = lx_len;
                lx_phase = PH_ZERO;
                return ST_CONSUMED;
            end
            ".": begin
                lx_int_end = lx_len;
                lx_pt = 1'b1;
                lex_take();
                lx_phase = PH_MANT;
                return ST_CONSUMED;
            end
            default: begin
                if (is_dec(c)) begin
                    lex_take();
                    lx_mant = 1'b1;
                    lx_int_end = lx_len;
                    lx_phase = PH_MANT;
                    return ST_CONSUMED;
                end
                return ST_NOT_LITERAL;
            end
        endcase
    endfunction

    function automatic t_result lex_step(input logic [7:0] c, input logic eot);
        logic [1:0] st;
        t_result    r;
        case (lx_phase)
            PH_START, PH_SIGN: st = lex_start(c, eot);
            PH_NAN_A:    st = lex_word(c, eot, "a", PH_NAN_N);
            PH_NAN_N:    st = lex_word(c, eot, "n", PH_WORD_END);
            PH_CNAN_A:   st = lex_word(c, eot, "a", PH_CNAN_N);
            PH_CNAN_N:   st = lex_word(c, eot, "N", PH_WORD_END);
            PH_INF_N:    st = lex_word(c, eot, "n", PH_INF_F);
            PH_INF_F:    st = lex_word(c, eot, "f", PH_WORD_END);
            PH_WORD_END: begin
                if (!eot && c == " ") begin
                    lex_take();
                    lx_phase = PH_SPACE_I;
                    st = ST_CONSUMED;
                end else begin
                    st = ST_COMPLETE;
                end
            end
            PH_SPACE_I: begin
                if (!eot && c == "i") begin
                    lx_imag = 1'b1;
                    lex_take();
                    lx_phase = PH_DONE;
                    st = ST_CONSUMED;
                end else begin
                    st = ST_MALFORMED;
                end
            end
            PH_ZERO: begin
                if (eot) begin
                    st = ST_COMPLETE;
                end else if ((c | 8'h20) == "x") begin
                    lx_hex = 1'b1;
                    lx_int_end = '0;
                    lex_take();
                    lx_phase = PH_MANT;
                    st = ST_CONSUMED;
                end else begin
                    lx_mant = 1'b1;
                    lx_phase = PH_MANT;
                    st = lex_mant(c, eot);
                end
            end
            PH_MANT:     st = lex_mant(c, eot);
            PH_EXP_SIGN: begin
                lx_phase = PH_EXP_DIG;
                if (!eot && (c == "+" || c == "-")) begin
                    lex_take();
                    st = ST_CONSUMED;
                end else begin
                    st = lex_exp_digit(c, eot);
                end
            end
            PH_EXP_DIG:  st = lex_exp_digit(c, eot);
            PH_DONE:     st = ST_COMPLETE;
            default:     st = ST_NOT_LITERAL;
        endcase
        r = '0;
        r.status = st;
        if (st == ST_CONSUMED || st == ST_COMPLETE) begin
            r.literal_length = lx_len;
            r.hex_form = lx_hex;
            r.point_seen = lx_pt;
            r.exponent_seen = lx_expo;
            r.imaginary = lx_imag;
            r.integral_end = lx_int_end;
            r.exponent_start = lx_exp_start;
        end
        if (st != ST_CONSUMED) begin
            lex_clear();
        end
        return r;
    endfunction

    task automatic add_item(input logic [7:0] c, input logic eot);
        char_stream.push_back('{c, eot, 1'b0, RES_NONE});
    endtask

    task automatic compare_result(input t_result want, input t_result got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.literal_length !== want.literal_length) begin
            $error("literal_length: expected %0d, got %0d",
                   want.literal_length, got.literal_length);
            fail_count++;
        end
        if (got.hex_form !== want.hex_form) begin
            $error("hex_form: expected %0d, got %0d", want.hex_form, got.hex_form);
            fail_count++;
        end
        if (got.point_seen !== want.point_seen) begin
            $error("point_seen: expected %0d, got %0d", want.point_seen, got.point_seen);
            fail_count++;
        end
        if (got.exponent_seen !== want.exponent_seen) begin
            $error("exponent_seen: expected %0d, got %0d",
                   want.exponent_seen, got.exponent_seen);
            fail_count++;
        end
        if (got.imaginary !== want.imaginary) begin
            $error("imaginary: expected %0d, got %0d", want.imaginary, got.imaginary);
            fail_count++;
        end
        if (got.integral_end !== want.integral_end) begin
            $error("integral_end: expected %0d, got %0d",
                   want.integral_end, got.integral_end);
            fail_count++;
        end
        if (got.exponent_start !== want.exponent_start) begin
            $error("exponent_start: expected %0d, got %0d",
                   want.exponent_start, got.exponent_start);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_result predicted;
        t_result seen;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predicted = lex_step(i_ch, i_end_of_text);
                pending_results.push_back(req_hand ? req_want : predicted);
            end
            if (o_valid && !i_stall) begin
                seen = '{o_status, o_literal_length, o_hex_form, o_point_seen,
                         o_exponent_seen, o_imaginary, o_integral_end, o_exponent_start};
                if (pending_results.size() == 0) begin
                    $error("status: expected no result, got %0d", o_status);
                    fail_count++;
                end else begin
                    compare_result(pending_results.pop_front(), seen);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // The receiver stalls at random, then holds off long enough for the lexer
    // to fill up and push back on the sender, then keeps a pattern of its own.
    initial begin : receiver
        int mode;
        int seg;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        repeat (120) begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(0, 2) == 0);
        end
        repeat (80) begin
            @(negedge i_clk);
            i_stall <= 1'b1;
        end
        forever begin
            mode = $urandom_range(0, 9);
            seg = (mode == 9) ? $urandom_range(30, 70) : $urandom_range(5, 40);
            repeat (seg) begin
                @(negedge i_clk);
                if (mode < 4) begin
                    i_stall <= 1'b0;
                end else if (mode < 7) begin
                    i_stall <= ($urandom_range(0, 2) == 0);
                end else if (mode < 9) begin
                    i_stall <= ($urandom_range(0, 3) != 0);
                end else begin
                    i_stall <= 1'b1;
                end
            end
        end
    end

    initial begin : sender
        logic [23:0] word;
        logic [7:0]  marker;
        logic        hex;
        int          n;
        int          letters;
        int          burst_left;
        int          gap_len;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ch = 8'h00;
        i_end_of_text = 1'b0;
        req_hand = 1'b0;
        req_want = RES_NONE;
        lex_clear();

        directed_table = '{
            '{8'h00, 1'b1, 1'b1, RES_NOT_LIT},
            '{8'hFF, 1'b0, 1'b1, RES_NOT_LIT},
            '{8'h00, 1'b0, 1'b1, RES_NOT_LIT},
            '{"-",   1'b0, 1'b0, RES_NONE},
            '{8'hFF, 1'b1, 1'b1, RES_MALFORMED},
            '{"-",   1'b0, 1'b0, RES_NONE},
            '{"#",   1'b0, 1'b1, RES_NOT_LIT},
            '{"n",   1'b0, 1'b0, RES_NONE},
            '{"a",   1'b0, 1'b0, RES_NONE},
            '{"x",   1'b0, 1'b1, RES_MALFORMED},
            '{"0",   1'b0, 1'b0, RES_NONE},
            '{8'h00, 1'b1, 1'b1, RES_LONE_ZERO},
            '{"0",   1'b0, 1'b0, RES_NONE},
            '{"x",   1'b0, 1'b0, RES_NONE},
            '{"g",   1'b0, 1'b1, RES_MALFORMED},
            '{".",   1'b0, 1'b0, RES_NONE},
            '{8'h00, 1'b1, 1'b1, RES_MALFORMED},
            '{"0",   1'b0, 1'b0, RES_NONE},
            '{"X",   1'b0, 1'b0, RES_NONE},
            '{"a",   1'b0, 1'b0, RES_NONE},
            '{".",   1'b0, 1'b0, RES_NONE},
            '{"B",   1'b0, 1'b0, RES_NONE},
            '{"p",   1'b0, 1'b0, RES_NONE},
            '{"+",   1'b0, 1'b0, RES_NONE},
            '{"7",   1'b0, 1'b0, RES_NONE},
            '{"i",   1'b0, 1'b0, RES_NONE},
            '{" ",   1'b0, 1'b0, RES_NONE}
        };
        foreach (directed_table[r]) begin
            char_stream.push_back(directed_table[r]);
        end

        // Mostly well-formed literals with random content, some of them cut
        // short, mixed with noise characters and stray end-of-text marks.
        while (char_stream.size() < TABLE_ROWS + RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    add_item(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
                end
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    add_item("-", 1'b0);
                end
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 2))
                        0: word = "nan";
                        1: word = "NaN";
                        default: word = "inf";
                    endcase
                    letters = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 3;
                    for (int j = 0; j < letters; j++) begin
                        add_item(word[23 - 8 * j -: 8], 1'b0);
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        add_item(" ", 1'b0);
                        if ($urandom_range(0, 5) != 0) begin
                            add_item("i", 1'b0);
                        end
                    end
                end else begin
                    hex = ($urandom_range(0, 2) == 0);
                    if (hex) begin
                        add_item("0", 1'b0);
                        add_item(($urandom_range(0, 1) == 1) ? "x" : "X", 1'b0);
                    end
                    for (int part = 0; part < 2; part++) begin
                        if (part == 1) begin
                            if ($urandom_range(0, 1) == 0) begin
                                break;
                            end
                            add_item(".", 1'b0);
                        end
                        n = $urandom_range(0, 4);
                        repeat (n) begin
                            if (hex) begin
                                letters = $urandom_range(0, 21);
                                if (letters < 10) begin
                                    add_item(8'("0" + letters), 1'b0);
                                end else if (letters < 16) begin
                                    add_item(8'("a" + letters - 10), 1'b0);
                                end else begin
                                    add_item(8'("A" + letters - 16), 1'b0);
                                end
                            end else begin
                                add_item(8'("0" + $urandom_range(0, 9)), 1'b0);
                            end
                        end
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        marker = hex ? "p" : "e";
                        if ($urandom_range(0, 1) == 1) begin
                            marker = marker & 8'hDF;
                        end
                        add_item(marker, 1'b0);
                        case ($urandom_range(0, 2))
                            0: add_item("+", 1'b0);
                            1: add_item("-", 1'b0);
                            default: ;
                        endcase
                        repeat ($urandom_range(0, 3)) begin
                            add_item(8'("0" + $urandom_range(0, 9)), 1'b0);
                        end
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        add_item("i", 1'b0);
                    end
                end
                if ($urandom_range(0, 3) == 0) begin
                    add_item(8'($urandom_range(0, 255)), 1'b1);
                end else begin
                    add_item(8'($urandom_range(0, 255)), 1'b0);
                end
            end
        end

        // One long literal drives the length and the exponent start into saturation.
        add_item(8'("1" + $urandom_range(0, 8)), 1'b0);
        repeat ($urandom_range(250, 270)) begin
            add_item(8'("0" + $urandom_range(0, 9)), 1'b0);
        end
        add_item(".", 1'b0);
        repeat ($urandom_range(5, 20)) begin
            add_item(8'("0" + $urandom_range(0, 9)), 1'b0);
        end
        add_item("E", 1'b0);
        add_item("-", 1'b0);
        add_item("3", 1'b0);
        add_item("i", 1'b0);
        add_item(8'h00, 1'b1);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        burst_left = 0;
        foreach (char_stream[idx]) begin
            @(negedge i_clk);
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap_len > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap_len) @(negedge i_clk);
                end
            end
            burst_left--;
            i_valid <= 1'b1;
            i_ch <= char_stream[idx].ch;
            i_end_of_text <= char_stream[idx].eot;
            req_hand <= char_stream[idx].hand;
            req_want <= char_stream[idx].want;
            do begin
                @(posedge i_clk);
            end while (o_stall);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
